// File: hdl/scsa_pkg.sv
package scsa_pkg;

	localparam int SLOTS_PER_CLASS = 4096;
	localparam int NUM_CLASSES     = 6;
	localparam int BASE_BYTES      = 8;

	// fixed field widths
	localparam int REQ_W  = 16;
	localparam int CLS_W  = 3;
	localparam int SLOT_W = 12;
	localparam int ST_W   = 3;

	// head and bump counters hold SLOTS_PER_CLASS itself (empty mark / pool used up)
	localparam int CNT_W      = $clog2(SLOTS_PER_CLASS) + 1;
	localparam int CLS_IDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int LINK_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
	localparam int LINK_AW    = $clog2(LINK_DEPTH);

	localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(SLOTS_PER_CLASS);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_REUSED    = 3'd0,
		ST_FRESH     = 3'd1,
		ST_FREED     = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_NO_MEMORY = 3'd4
	} status_t;

	typedef struct packed {
		logic                 too_large;
		logic [CLS_W-1:0]     cls;
	} cls_map_t;

	// class table write-back for one item
	typedef struct packed {
		logic                 head_we;
		logic                 bump_we;
		logic [CLS_IDX_W-1:0] idx;
		logic [CNT_W-1:0]     head;
		logic [CNT_W-1:0]     bump;
	} upd_t;

	// smallest class whose slot holds size; size 0 lands in class 0
	function automatic cls_map_t size_class(input logic [REQ_W-1:0] size);
		cls_map_t r;
		r.too_large = 1'b1;
		r.cls       = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (32'(size) <= (BASE_BYTES << c)) begin
				r.too_large = 1'b0;
				r.cls       = CLS_W'(c);
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/scsa_link_mem.sv
module scsa_link_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [scsa_pkg::LINK_AW-1:0] waddr,
	input  logic [scsa_pkg::CNT_W-1:0]   wdata,
	input  logic                         re,
	input  logic [scsa_pkg::LINK_AW-1:0] raddr,
	output logic [scsa_pkg::CNT_W-1:0]   rdata_q
);

	logic [scsa_pkg::CNT_W-1:0] mem [0:scsa_pkg::LINK_DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// File: hdl/scsa_class_tbl.sv
module scsa_class_tbl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [scsa_pkg::CLS_IDX_W-1:0] rd_idx,
	output logic [scsa_pkg::CNT_W-1:0]     head,
	output logic [scsa_pkg::CNT_W-1:0]     bump,
	input  scsa_pkg::upd_t                 upd
);

	logic [scsa_pkg::CNT_W-1:0] head_q [scsa_pkg::NUM_CLASSES];
	logic [scsa_pkg::CNT_W-1:0] bump_q [scsa_pkg::NUM_CLASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < scsa_pkg::NUM_CLASSES; c++) begin
				head_q[c] <= scsa_pkg::EMPTY_MARK;
				bump_q[c] <= '0;
			end
		end else begin
			if (upd.head_we) begin
				head_q[upd.idx] <= upd.head;
			end
			if (upd.bump_we) begin
				bump_q[upd.idx] <= upd.bump;
			end
		end
	end

	assign head = head_q[rd_idx];
	assign bump = bump_q[rd_idx];

endmodule

// File: hdl/size_class_slab_allocator.sv
// Slab allocator over NUM_CLASSES power-of-two size classes (8 to 256 bytes by
// default). Allocate pops the class's reuse stack, else takes the next fresh
// slot; free pushes the slot back. Each item goes through stage 1, which reads the
// class head and issues the next-link memory access, then stage 2, which takes the
// link read data and writes the head or bump back. The result sits in an output
// register, so the next item is taken while a result still waits. The next-link
// memory needs no clearing; only links written by frees are ever followed. Frees
// are not checked against earlier grants.
module size_class_slab_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [scsa_pkg::REQ_W-1:0]  request_size,
	input  logic [scsa_pkg::CLS_W-1:0]  free_class,
	input  logic [scsa_pkg::SLOT_W-1:0] free_slot,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scsa_pkg::CLS_W-1:0]  granted_class,
	output logic [scsa_pkg::SLOT_W-1:0] granted_slot,
	output logic [scsa_pkg::ST_W-1:0]   status
);

	// stage 1: decoded request
	logic                        v_s1;
	logic                        free_s1;
	logic                        bad_s1;
	logic [scsa_pkg::CLS_W-1:0]  cls_s1;
	logic [scsa_pkg::SLOT_W-1:0] slot_s1;

	// stage 2: result and pending write-back
	logic                        v_s2;
	logic                        pop_s2;
	logic [scsa_pkg::CLS_W-1:0]  cls_s2;
	logic [scsa_pkg::SLOT_W-1:0] slot_s2;
	scsa_pkg::status_t           st_s2;
	scsa_pkg::upd_t              upd_s2;

	logic                        out_valid_q;
	logic [scsa_pkg::CLS_W-1:0]  cls_q;
	logic [scsa_pkg::SLOT_W-1:0] slot_q;
	scsa_pkg::status_t           st_q;

	logic                        accept;
	logic                        s1_go;
	logic                        s2_go;
	scsa_pkg::cls_map_t          map;
	logic                        free_ok;

	logic [scsa_pkg::CLS_IDX_W-1:0] idx;
	logic [scsa_pkg::CNT_W-1:0]     head;
	logic [scsa_pkg::CNT_W-1:0]     bump;
	logic [scsa_pkg::LINK_AW-1:0]   base;
	logic                           mem_we;
	logic                           mem_re;
	logic [scsa_pkg::LINK_AW-1:0]   mem_addr;
	logic [scsa_pkg::CNT_W-1:0]     link_rdata;

	logic                        pop_d;
	logic [scsa_pkg::CLS_W-1:0]  cls_d;
	logic [scsa_pkg::SLOT_W-1:0] slot_d;
	scsa_pkg::status_t           st_d;
	scsa_pkg::upd_t              upd_d;
	scsa_pkg::upd_t              tbl_upd;

	// s1 only moves on with s2 empty, so the head it reads is never stale
	assign s1_go    = v_s1 && !v_s2;
	assign s2_go    = v_s2 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && v_s2;
	assign accept   = in_valid && !in_stall;

	assign map     = scsa_pkg::size_class(request_size);
	assign free_ok = (32'(free_class) < scsa_pkg::NUM_CLASSES) &&
	                 (32'(free_slot) < scsa_pkg::SLOTS_PER_CLASS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			free_s1 <= (command == scsa_pkg::CMD_FREE);
			if (command == scsa_pkg::CMD_FREE) begin
				bad_s1  <= !free_ok;
				cls_s1  <= free_class;
				slot_s1 <= free_slot;
			end else begin
				bad_s1  <= map.too_large;
				cls_s1  <= map.cls;
				slot_s1 <= '0;
			end
		end
	end

	assign idx  = bad_s1 ? '0 : scsa_pkg::CLS_IDX_W'(cls_s1);
	assign base = scsa_pkg::LINK_AW'(idx) * scsa_pkg::LINK_AW'(scsa_pkg::SLOTS_PER_CLASS);

	scsa_class_tbl u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx),
		.head   (head),
		.bump   (bump),
		.upd    (tbl_upd)
	);

	always_comb begin
		pop_d        = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_addr     = base + scsa_pkg::LINK_AW'(head);
		cls_d        = cls_s1;
		slot_d       = slot_s1;
		st_d         = scsa_pkg::ST_TOO_LARGE;
		upd_d        = '0;
		upd_d.idx    = idx;
		upd_d.head   = scsa_pkg::CNT_W'(slot_s1);
		upd_d.bump   = bump + 1'b1;
		if (free_s1) begin
			if (!bad_s1) begin
				// push: new link points at old head
				mem_we        = s1_go;
				mem_addr      = base + scsa_pkg::LINK_AW'(slot_s1);
				st_d          = scsa_pkg::ST_FREED;
				upd_d.head_we = 1'b1;
			end
		end else if (bad_s1) begin
			cls_d  = '0;
			slot_d = '0;
		end else if (head != scsa_pkg::EMPTY_MARK) begin
			mem_re        = s1_go;
			pop_d         = 1'b1;
			slot_d        = scsa_pkg::SLOT_W'(head);
			st_d          = scsa_pkg::ST_REUSED;
			upd_d.head_we = 1'b1;
		end else if (bump != scsa_pkg::EMPTY_MARK) begin
			slot_d        = scsa_pkg::SLOT_W'(bump);
			st_d          = scsa_pkg::ST_FRESH;
			upd_d.bump_we = 1'b1;
		end else begin
			slot_d = '0;
			st_d   = scsa_pkg::ST_NO_MEMORY;
		end
	end

	scsa_link_mem u_link (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_addr),
		.wdata   (head),
		.re      (mem_re),
		.raddr   (mem_addr),
		.rdata_q (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_go) begin
			v_s2 <= 1'b1;
		end else if (s2_go) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			pop_s2  <= pop_d;
			cls_s2  <= cls_d;
			slot_s2 <= slot_d;
			st_s2   <= st_d;
			upd_s2  <= upd_d;
		end
	end

	// pop takes the successor straight from the link read data
	always_comb begin
		tbl_upd         = upd_s2;
		tbl_upd.head_we = upd_s2.head_we && s2_go;
		tbl_upd.bump_we = upd_s2.bump_we && s2_go;
		if (pop_s2) begin
			tbl_upd.head = link_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			cls_q  <= cls_s2;
			slot_q <= slot_s2;
			st_q   <= st_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted_class = cls_q;
	assign granted_slot  = slot_q;
	assign status        = st_q;

endmodule

// File: verif/size_class_slab_allocator_tb.sv
module size_class_slab_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int TOP_CLASS    = scsa_pkg::NUM_CLASSES - 1;

	typedef struct packed {
		logic [scsa_pkg::CLS_W-1:0]  cls;
		logic [scsa_pkg::SLOT_W-1:0] slot;
		scsa_pkg::status_t           st;
	} grant_t;

	typedef struct {
		logic [scsa_pkg::CLS_W-1:0]  cls;
		logic [scsa_pkg::SLOT_W-1:0] slot;
	} slot_ref_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        command;
	logic [scsa_pkg::REQ_W-1:0]  request_size;
	logic [scsa_pkg::CLS_W-1:0]  free_class;
	logic [scsa_pkg::SLOT_W-1:0] free_slot;
	logic                        out_valid;
	logic                        out_stall;
	logic [scsa_pkg::CLS_W-1:0]  granted_class;
	logic [scsa_pkg::SLOT_W-1:0] granted_slot;
	logic [scsa_pkg::ST_W-1:0]   status;

	// shadow allocator state
	logic [scsa_pkg::CNT_W-1:0] bump_cnt [scsa_pkg::NUM_CLASSES];
	logic [scsa_pkg::CNT_W-1:0] stack_top [scsa_pkg::NUM_CLASSES];
	logic [scsa_pkg::CNT_W-1:0] link_mem [int];

	grant_t    grant_q [$];
	slot_ref_t live_q [$];
	grant_t    head_grant;

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  hold_off = 0;
	bit  tx_idle_on = 1'b0;
	bit  rx_idle_on = 1'b0;
	int  rx_run = 0;
	bit  rx_stalling = 1'b0;

	size_class_slab_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.request_size  (request_size),
		.free_class    (free_class),
		.free_slot     (free_slot),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.granted_class (granted_class),
		.granted_slot  (granted_slot),
		.status        (status)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic logic [scsa_pkg::REQ_W-1:0] size_for_class(int c);
		int lo;
		int hi;
		lo = (c == 0) ? 0 : (scsa_pkg::BASE_BYTES << (c - 1)) + 1;
		hi = scsa_pkg::BASE_BYTES << c;
		return scsa_pkg::REQ_W'($urandom_range(hi, lo));
	endfunction

	function automatic grant_t predict_grant(scsa_pkg::cmd_t cmd,
			logic [scsa_pkg::REQ_W-1:0] size, logic [scsa_pkg::CLS_W-1:0] fcls,
			logic [scsa_pkg::SLOT_W-1:0] fslot);
		grant_t g;
		int c;
		int top;
		g.cls  = '0;
		g.slot = '0;
		g.st   = scsa_pkg::ST_TOO_LARGE;
		if (cmd == scsa_pkg::CMD_FREE) begin
			g.cls  = fcls;
			g.slot = fslot;
			if (int'(fcls) < scsa_pkg::NUM_CLASSES &&
					int'(fslot) < scsa_pkg::SLOTS_PER_CLASS) begin
				link_mem[int'(fcls) * scsa_pkg::SLOTS_PER_CLASS + int'(fslot)] =
					stack_top[fcls];
				stack_top[fcls] = scsa_pkg::CNT_W'(fslot);
				g.st = scsa_pkg::ST_FREED;
			end
			return g;
		end
		c = 0;
		while (c < scsa_pkg::NUM_CLASSES && (scsa_pkg::BASE_BYTES << c) < int'(size))
			c++;
		if (c >= scsa_pkg::NUM_CLASSES)
			return g;
		g.cls = scsa_pkg::CLS_W'(c);
		if (stack_top[c] < scsa_pkg::EMPTY_MARK) begin
			top = int'(stack_top[c]);
			g.slot = scsa_pkg::SLOT_W'(top);
			g.st = scsa_pkg::ST_REUSED;
			stack_top[c] = link_mem[c * scsa_pkg::SLOTS_PER_CLASS + top];
		end else if (bump_cnt[c] < scsa_pkg::EMPTY_MARK) begin
			g.slot = scsa_pkg::SLOT_W'(bump_cnt[c]);
			g.st = scsa_pkg::ST_FRESH;
			bump_cnt[c] = bump_cnt[c] + 1'b1;
		end else begin
			g.st = scsa_pkg::ST_NO_MEMORY;
		end
		return g;
	endfunction

	task automatic send_beat(scsa_pkg::cmd_t cmd, logic [scsa_pkg::REQ_W-1:0] size,
			logic [scsa_pkg::CLS_W-1:0] fcls, logic [scsa_pkg::SLOT_W-1:0] fslot);
		grant_t g;
		slot_ref_t r;
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		command = cmd;
		request_size = size;
		free_class = fcls;
		free_slot = fslot;
		do @(posedge clk); while (in_stall);
		g = predict_grant(cmd, size, fcls, fslot);
		grant_q.push_back(g);
		if (g.st == scsa_pkg::ST_REUSED || g.st == scsa_pkg::ST_FRESH) begin
			r.cls = g.cls;
			r.slot = g.slot;
			live_q.push_back(r);
		end
		gap = tx_idle_on ? idle_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drain();
		drop_valid();
		while (grant_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// receiver: forced hold-off first, else random stall stretches
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_stall = 1'b1;
				hold_off--;
			end else if (!rx_idle_on) begin
				out_stall = 1'b0;
			end else begin
				if (rx_run == 0) begin
					rx_stalling = ($urandom_range(0, 2) == 0);
					rx_run = rx_stalling ? idle_len() + 1 : $urandom_range(1, 20);
				end
				out_stall = rx_stalling;
				rx_run--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result beat with nothing pending: class %0d slot %0d status %0d",
						granted_class, granted_slot, status);
			end else begin
				head_grant = grant_q.pop_front();
				check_field("granted_class", head_grant.cls, granted_class);
				check_field("granted_slot", head_grant.slot, granted_slot);
				check_field("status", head_grant.st, status);
			end
		end
	end

	task automatic test_directed();
		int c;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// class boundaries, size 0 included
		send_beat(scsa_pkg::CMD_ALLOC, 16'd0, 3'd7, 12'hFFF);
		for (c = 0; c < scsa_pkg::NUM_CLASSES; c++) begin
			send_beat(scsa_pkg::CMD_ALLOC, scsa_pkg::REQ_W'(scsa_pkg::BASE_BYTES << c),
				'0, '0);
			send_beat(scsa_pkg::CMD_ALLOC,
				scsa_pkg::REQ_W'((scsa_pkg::BASE_BYTES << c) + 1), '0, '0);
		end
		send_beat(scsa_pkg::CMD_ALLOC, 16'hFFFF, 3'd5, 12'hABC);
		// push then pop back the same slot
		send_beat(scsa_pkg::CMD_FREE, 16'hFFFF, 3'd0, 12'd0);
		send_beat(scsa_pkg::CMD_ALLOC, 16'd1, '0, '0);
		// free of a slot never handed out
		send_beat(scsa_pkg::CMD_FREE, 16'd0, 3'd1, 12'd4095);
		send_beat(scsa_pkg::CMD_ALLOC, 16'd10, '0, '0);
		// class out of range is echoed
		send_beat(scsa_pkg::CMD_FREE, 16'd0, 3'd6, 12'd5);
		send_beat(scsa_pkg::CMD_FREE, 16'h5555, 3'd7, 12'd4095);
		wait_drain();
	endtask

	task automatic random_mix(int count);
		int k;
		int pick;
		int idx;
		slot_ref_t s;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 52) begin
				send_beat(scsa_pkg::CMD_ALLOC,
					size_for_class($urandom_range(0, scsa_pkg::NUM_CLASSES - 1)),
					scsa_pkg::CLS_W'($urandom), scsa_pkg::SLOT_W'($urandom));
			end else if (pick < 82 && live_q.size() > 0) begin
				idx = $urandom_range(0, live_q.size() - 1);
				s = live_q[idx];
				live_q.delete(idx);
				send_beat(scsa_pkg::CMD_FREE, scsa_pkg::REQ_W'($urandom), s.cls, s.slot);
			end else if (pick < 87) begin
				send_beat(scsa_pkg::CMD_FREE, scsa_pkg::REQ_W'($urandom),
					scsa_pkg::CLS_W'($urandom_range(0, scsa_pkg::NUM_CLASSES - 1)),
					scsa_pkg::SLOT_W'($urandom));
			end else if (pick < 92) begin
				send_beat(scsa_pkg::CMD_FREE, scsa_pkg::REQ_W'($urandom),
					scsa_pkg::CLS_W'($urandom_range(scsa_pkg::NUM_CLASSES, 7)),
					scsa_pkg::SLOT_W'($urandom));
			end else if (pick < 96) begin
				send_beat(scsa_pkg::CMD_ALLOC, scsa_pkg::REQ_W'($urandom_range(65535, 257)),
					scsa_pkg::CLS_W'($urandom), scsa_pkg::SLOT_W'($urandom));
			end else begin
				send_beat(scsa_pkg::CMD_ALLOC, scsa_pkg::REQ_W'($urandom),
					scsa_pkg::CLS_W'($urandom), scsa_pkg::SLOT_W'($urandom));
			end
		end
	endtask

	task automatic test_random();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		random_mix(300);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_mix(250);
		tx_idle_on = 1'b1;
		random_mix(200);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		random_mix(200);
		wait_drain();
	endtask

	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		@(posedge clk);
		hold_off = 150;
		random_mix(24);
		wait_drain();
	endtask

	task automatic test_pool_exhaustion();
		logic [scsa_pkg::REQ_W-1:0] top_size;
		top_size = scsa_pkg::REQ_W'(scsa_pkg::BASE_BYTES << TOP_CLASS);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (!(stack_top[TOP_CLASS] == scsa_pkg::EMPTY_MARK &&
				bump_cnt[TOP_CLASS] == scsa_pkg::EMPTY_MARK))
			send_beat(scsa_pkg::CMD_ALLOC, top_size, '0, '0);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_beat(scsa_pkg::CMD_ALLOC, top_size, '0, '0);
		send_beat(scsa_pkg::CMD_ALLOC,
			scsa_pkg::REQ_W'((scsa_pkg::BASE_BYTES << (TOP_CLASS - 1)) + 1), '0, '0);
		send_beat(scsa_pkg::CMD_FREE, '0, scsa_pkg::CLS_W'(TOP_CLASS), 12'd4095);
		send_beat(scsa_pkg::CMD_FREE, '0, scsa_pkg::CLS_W'(TOP_CLASS), 12'd17);
		send_beat(scsa_pkg::CMD_ALLOC, top_size, '0, '0);
		send_beat(scsa_pkg::CMD_ALLOC, top_size, '0, '0);
		send_beat(scsa_pkg::CMD_ALLOC, top_size, '0, '0);
		random_mix(150);
		wait_drain();
	endtask

	task automatic test_unchecked_frees();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// same slot freed twice: its link points at itself
		send_beat(scsa_pkg::CMD_FREE, '0, 3'd2, 12'd7);
		send_beat(scsa_pkg::CMD_FREE, '0, 3'd2, 12'd7);
		send_beat(scsa_pkg::CMD_ALLOC, 16'd20, '0, '0);
		send_beat(scsa_pkg::CMD_ALLOC, 16'd32, '0, '0);
		send_beat(scsa_pkg::CMD_ALLOC, 16'd17, '0, '0);
		send_beat(scsa_pkg::CMD_FREE, '0, 3'd3, 12'd4000);
		send_beat(scsa_pkg::CMD_ALLOC, 16'd64, '0, '0);
		random_mix(60);
		wait_drain();
	endtask

	initial begin
		int c;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = scsa_pkg::CMD_ALLOC;
		request_size = '0;
		free_class = '0;
		free_slot = '0;
		for (c = 0; c < scsa_pkg::NUM_CLASSES; c++) begin
			bump_cnt[c] = '0;
			stack_top[c] = scsa_pkg::EMPTY_MARK;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		// run before random frees can loop the top class's reuse stack
		test_pool_exhaustion();
		test_random();
		test_backpressure();
		test_unchecked_frees();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && grant_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
